FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the queue RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define FQS_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("fqs: assertion failed");

// Next-cycle implication, disabled in reset.
`define FQS_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("fqs: assertion failed");

`endif

FILE: rtl/core/fqs_pkg.sv
// Package for the FIFO queue with search: field widths, action and status codes.
// No dependencies; used by the interfaces, fqs_ctrl and the top level.
package fqs_pkg;

  localparam int FQS_DEPTH    = 16;
  localparam int FQS_DATA_W   = 32;
  localparam int FQS_ACTION_W = 2;
  localparam int FQS_STATUS_W = 2;
  localparam int FQS_POS_W    = 5;

  typedef enum logic [FQS_ACTION_W-1:0] {
    ACT_ENQ    = 2'd0,
    ACT_DEQ    = 2'd1,
    ACT_VIEW   = 2'd2,
    ACT_SEARCH = 2'd3
  } fqs_action_t;

  typedef enum logic [FQS_STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } fqs_status_t;

endpackage

FILE: rtl/core/fqs_if.sv
// Valid/ready channel interfaces for the queue: command items in, result items out.
// Depends on fqs_pkg for field widths.
interface fqs_cmd_if import fqs_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic        [FQS_ACTION_W-1:0] action;
  logic signed [FQS_DATA_W-1:0]   data_value;

  modport source (output valid, action, data_value, input ready);
  modport sink (input valid, action, data_value, output ready);
endinterface

interface fqs_rsp_if import fqs_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic        [FQS_STATUS_W-1:0] status;
  logic signed [FQS_DATA_W-1:0]   out_value;
  logic        [FQS_POS_W-1:0]    position;
  logic                           last;

  modport source (output valid, status, out_value, position, last, input ready);
  modport sink (input valid, status, out_value, position, last, output ready);
endinterface

FILE: rtl/core/fqs_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module fqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/fqs_ctrl.sv
// Queue sequencer: head and count registers, store access and the result register.
// Depends on fqs_pkg, fqs_if and assert_macros.svh; drives one fqs_ram.
`include "assert_macros.svh"

module fqs_ctrl import fqs_pkg::*; #(
  parameter int QUEUE_DEPTH = FQS_DEPTH,
  parameter int IW          = $clog2(QUEUE_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  fqs_cmd_if.sink               cmd,
  fqs_rsp_if.source             rsp,
  output logic                  wr_en,
  output logic [IW-1:0]         wr_addr,
  output logic [FQS_DATA_W-1:0] wr_data,
  output logic                  rd_en,
  output logic [IW-1:0]         rd_addr,
  input  logic [FQS_DATA_W-1:0] rd_data
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK
  } state_t;

  state_t                  state;
  fqs_action_t             act;
  logic [FQS_DATA_W-1:0]   key;
  logic [IW-1:0]           head;
  logic [CW-1:0]           count;
  logic [IW-1:0]           ptr;
  logic [CW-1:0]           idx;

  logic                    cmd_acc;
  logic                    out_free;
  logic                    full;
  logic                    empty;
  logic [CW:0]             tail_sum;
  logic [CW:0]             tail_wrap;
  logic [IW-1:0]           head_next;
  logic [IW-1:0]           ptr_next;
  logic [CW-1:0]           idx_inc;
  logic                    idx_last;
  logic                    hit;
  logic                    walk_read;
  logic                    walk_start;
  logic                    rsp_load;

  assign cmd.ready = (state == S_IDLE);
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign out_free  = !rsp.valid || rsp.ready;
  assign full      = (count == CW'(QUEUE_DEPTH));
  assign empty     = (count == '0);

  assign tail_sum  = (CW+1)'(head) + (CW+1)'(count);
  assign tail_wrap = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                     tail_sum - (CW+1)'(QUEUE_DEPTH) : tail_sum;
  assign head_next = (head == IW'(QUEUE_DEPTH - 1)) ? '0 : head + IW'(1);
  assign ptr_next  = (ptr == IW'(QUEUE_DEPTH - 1)) ? '0 : ptr + IW'(1);
  assign idx_inc   = idx + CW'(1);
  assign idx_last  = (idx_inc == count);
  assign hit       = (rd_data == key);
  assign walk_start = (act == ACT_VIEW || act == ACT_SEARCH) && !empty;

  always_comb begin
    walk_read = 1'b0;
    if (state == S_WALK && !idx_last) begin
      if (act == ACT_VIEW) begin
        walk_read = out_free;
      end else begin
        walk_read = !hit;
      end
    end
  end

  always_comb begin
    rsp_load = 1'b0;
    if (out_free) begin
      if (state == S_EXEC) begin
        rsp_load = !walk_start;
      end else if (state == S_WALK) begin
        rsp_load = (act == ACT_VIEW) || hit || idx_last;
      end
    end
  end

  assign wr_en   = (state == S_EXEC) && (act == ACT_ENQ) && !full && out_free;
  assign wr_addr = tail_wrap[IW-1:0];
  assign wr_data = key;
  assign rd_en   = ((state == S_EXEC) && walk_start) || walk_read;
  assign rd_addr = (state == S_EXEC) ? head : ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
      head      <= '0;
      count     <= '0;
    end else begin
      if (rsp_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_acc) begin
            act   <= fqs_action_t'(cmd.action);
            key   <= cmd.data_value;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (walk_start) begin
            ptr   <= head_next;
            idx   <= '0;
            state <= S_WALK;
          end else if (out_free) begin
            rsp.out_value <= '0;
            rsp.position  <= '0;
            rsp.last      <= 1'b1;
            unique case (act)
              ACT_ENQ: begin
                if (full) begin
                  rsp.status <= ST_FULL;
                end else begin
                  rsp.status <= ST_OK;
                  count      <= count + CW'(1);
                end
              end
              ACT_DEQ: begin
                if (empty) begin
                  rsp.status <= ST_EMPTY;
                end else begin
                  rsp.status <= ST_OK;
                  head       <= head_next;
                  count      <= count - CW'(1);
                end
              end
              default: begin
                rsp.status <= ST_EMPTY;
              end
            endcase
            state <= S_IDLE;
          end
        end
        S_WALK: begin
          if (act == ACT_VIEW) begin
            if (out_free) begin
              rsp.status    <= ST_OK;
              rsp.out_value <= rd_data;
              rsp.position  <= '0;
              rsp.last      <= idx_last;
              if (idx_last) begin
                state <= S_IDLE;
              end else begin
                ptr <= ptr_next;
                idx <= idx_inc;
              end
            end
          end else if (hit || idx_last) begin
            if (out_free) begin
              rsp.status    <= hit ? ST_OK : ST_NOTFOUND;
              rsp.out_value <= '0;
              rsp.position  <= hit ? FQS_POS_W'(idx_inc) : '0;
              rsp.last      <= 1'b1;
              state         <= S_IDLE;
            end
          end else begin
            ptr <= ptr_next;
            idx <= idx_inc;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `FQS_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CW'(QUEUE_DEPTH))
  `FQS_ASSERT_NXT(a_write_grows, clk, rst, wr_en, count == $past(count) + CW'(1))
  `FQS_ASSERT_IMP(a_walk_nonempty, clk, rst, state == S_WALK, count != '0)
  `FQS_ASSERT_NXT(a_accept_exec, clk, rst, cmd_acc, state == S_EXEC)

endmodule

FILE: rtl/core/fifo_queue_with_search.sv
// Top level of the FIFO queue with search: sequencer plus entry store.
// Depends on fqs_pkg, fqs_if, fqs_ram and fqs_ctrl.
//
//   channel  dir  fields                                  handshake
//   cmd      in   action, data_value                      valid/ready
//   rsp      out  status, out_value, position, last       valid/ready
//
// Enqueue and dequeue: the item is registered on accept; EXEC loads the result once rsp
// is free and returns to IDLE, where ready is high again. View of n entries: results from
// the head, one per cycle while rsp is not stalled, last on the nth. Search reads on to a hit
// or the nth entry. Each step is one read through the single read port of the entry RAM.
// A stalled rsp holds a view walk and a search result; the next cmd item is taken while the
// last result still waits. Synchronous reset clears head and count; no clearing pass.
module fifo_queue_with_search import fqs_pkg::*; #(
  parameter int QUEUE_DEPTH = FQS_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  fqs_cmd_if.sink   cmd,
  fqs_rsp_if.source rsp
);

  localparam int IW = $clog2(QUEUE_DEPTH);

  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [FQS_DATA_W-1:0] wr_data;
  logic                  rd_en;
  logic [IW-1:0]         rd_addr;
  logic [FQS_DATA_W-1:0] rd_data;

  fqs_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .IW          (IW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rsp     (rsp),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  fqs_ram #(
    .WIDTH (FQS_DATA_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule
